// ===== hdl/shc_pkg.sv =====
// Sector header checker package: status codes, header field offsets,
// configuration and result types, and the CRC-16/CCITT-FALSE byte step.
// No dependencies.
package shc_pkg;

  localparam int HEADER_BYTES_DEF = 16;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_UNSUPP  = 3'd4;

  localparam logic [2:0] REG_MAGIC   = 3'd0;
  localparam logic [2:0] REG_VERSION = 3'd1;
  localparam logic [2:0] REG_OWNER_A = 3'd2;
  localparam logic [2:0] REG_OWNER_B = 3'd3;
  localparam logic [2:0] REG_FLAGS   = 3'd4;

  localparam int POS_MAGIC_LO = 0;
  localparam int POS_MAGIC_HI = 1;
  localparam int POS_VERSION  = 2;
  localparam int POS_OWNER    = 3;
  localparam int POS_SEQ_LO   = 4;
  localparam int POS_SEQ_HI   = 7;
  localparam int POS_SESS_LO  = 8;
  localparam int POS_SESS_HI  = 11;
  localparam int POS_RECORD   = 12;
  localparam int POS_FLAGS    = 13;

  localparam logic [7:0]  ERASED_BYTE = 8'hFF;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef struct packed {
    logic [15:0] magic_word;
    logic [7:0]  supported_version;
    logic [7:0]  owner_code_first;
    logic [7:0]  owner_code_second;
    logic [7:0]  session_flag_mask;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  version;
    logic [7:0]  owner;
    logic [31:0] sequence_res;
    logic [31:0] session_tag;
    logic [7:0]  record_len;
    logic        session_new;
  } res_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/shc_if.sv =====
// Valid/ready channel interfaces of the sector header checker: byte input
// and result output. No dependencies.
interface shc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface shc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  version;
  logic [7:0]  owner;
  logic [31:0] sequence_res;
  logic [31:0] session_tag;
  logic [7:0]  record_len;
  logic        session_new;

  modport source (output valid, status, version, owner, sequence_res, session_tag,
                  record_len, session_new, input ready);
  modport sink   (input valid, status, version, owner, sequence_res, session_tag,
                  record_len, session_new, output ready);
endinterface

// ===== hdl/shc_in_stage.sv =====
// Input register of the sector header checker: captures one byte item.
// Depends on shc_pkg and shc_in_if.
module shc_in_stage import shc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  shc_in_if.sink   in_i,
  input  logic     adv_i,
  output in_item_t item_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       first_q;

  assign in_i.ready = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q  <= in_i.data_byte;
      first_q <= in_i.first_byte;
    end
  end

  assign item_o = '{valid: valid_q, data_byte: byte_q, first_byte: first_q};

endmodule

// ===== hdl/shc_parser.sv =====
// Header parser: byte position, running CRC, erased flag, captured fields,
// and the result register. Depends on shc_pkg and shc_out_if.
module shc_parser import shc_pkg::*; #(
  parameter int HeaderBytes = HEADER_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     adv_o,
  shc_out_if.source res_o
);

  localparam int PosW = $clog2(HeaderBytes);
  localparam logic [PosW-1:0] LastPos  = PosW'(HeaderBytes - 1);
  localparam logic [PosW-1:0] CrcLoPos = PosW'(HeaderBytes - 2);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [15:0]     crc_q, crc_d, crc_eff;
  logic            erased_q, erased_d, erased_eff;
  logic [15:0]     magic_q;
  logic [7:0]      version_q;
  logic [7:0]      owner_q;
  logic [31:0]     seq_q;
  logic [31:0]     sess_q;
  logic [7:0]      record_q;
  logic [7:0]      flags_q;
  logic [7:0]      crc_lo_q;
  logic            res_valid_q;
  res_t            res_q, res_d;
  logic            last;
  logic            known;
  logic [7:0]      b;

  assign adv_o = !res_valid_q || res_o.ready;
  assign b     = item_i.data_byte;

  always_comb begin
    pos_eff    = item_i.first_byte ? '0 : pos_q;
    crc_eff    = item_i.first_byte ? CRC_INIT : crc_q;
    erased_eff = item_i.first_byte ? 1'b1 : erased_q;
    last       = (pos_eff == LastPos);
    erased_d   = erased_eff && (b == ERASED_BYTE);
    crc_d      = (pos_eff < CrcLoPos) ? crc16_step(crc_eff, b) : crc_eff;
    pos_d      = last ? '0 : pos_eff + PosW'(1);
    known      = (owner_q == cfg_i.owner_code_first) || (owner_q == cfg_i.owner_code_second);
    res_d      = '0;
    if (erased_d) begin
      res_d.status = ST_EMPTY;
    end else if (magic_q != cfg_i.magic_word) begin
      res_d.status = ST_MAGIC;
    end else if (crc_eff != {b, crc_lo_q}) begin
      res_d.status = ST_CRC;
    end else begin
      res_d.status       = (version_q == cfg_i.supported_version && known) ? ST_OK
                                                                           : ST_UNSUPP;
      res_d.version      = version_q;
      res_d.owner        = (res_d.status == ST_OK) ? owner_q : 8'h00;
      res_d.sequence_res = seq_q;
      res_d.session_tag  = sess_q;
      res_d.record_len   = record_q;
      res_d.session_new  = |(flags_q & cfg_i.session_flag_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      erased_q    <= 1'b1;
      res_valid_q <= 1'b0;
    end else if (adv_o) begin
      res_valid_q <= item_i.valid && last;
      if (item_i.valid) begin
        pos_q    <= pos_d;
        crc_q    <= last ? CRC_INIT : crc_d;
        erased_q <= last ? 1'b1 : erased_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && item_i.valid) begin
      case (pos_eff)
        PosW'(POS_MAGIC_LO): magic_q[7:0]  <= b;
        PosW'(POS_MAGIC_HI): magic_q[15:8] <= b;
        PosW'(POS_VERSION):  version_q     <= b;
        PosW'(POS_OWNER):    owner_q       <= b;
        PosW'(POS_RECORD):   record_q      <= b;
        PosW'(POS_FLAGS):    flags_q       <= b;
        default: begin
          if (pos_eff >= PosW'(POS_SEQ_LO) && pos_eff <= PosW'(POS_SEQ_HI)) begin
            seq_q[8*pos_eff[1:0] +: 8] <= b;
          end
          if (pos_eff >= PosW'(POS_SESS_LO) && pos_eff <= PosW'(POS_SESS_HI)) begin
            sess_q[8*pos_eff[1:0] +: 8] <= b;
          end
        end
      endcase
      if (pos_eff == CrcLoPos) begin
        crc_lo_q <= b;
      end
      if (last) begin
        res_q <= res_d;
      end
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.version      = res_q.version;
  assign res_o.owner        = res_q.owner;
  assign res_o.sequence_res = res_q.sequence_res;
  assign res_o.session_tag  = res_q.session_tag;
  assign res_o.record_len   = res_q.record_len;
  assign res_o.session_new  = res_q.session_new;

endmodule

// ===== hdl/sector_header_checker_core.sv =====
// Sector header checker top level: configuration registers, input stage,
// parser. Depends on shc_pkg, shc_if, shc_in_stage and shc_parser.
//
// Takes one header byte per cycle, with no gaps needed between headers. A byte
// passes the input register, then the parser updates position, CRC and fields;
// the result of a header is registered after its last byte leaves the input
// register. Throughput is one byte per cycle, with the CRC-16 byte step done
// combinationally; the only stall is a result left waiting at the output.
module sector_header_checker_core import shc_pkg::*; #(
  parameter int HeaderBytes = HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  shc_in_if.sink      in_i,
  shc_out_if.source   res_o
);

  cfg_t     cfg_q;
  in_item_t item;
  logic     adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word        <= 16'h0000;
      cfg_q.supported_version <= 8'h01;
      cfg_q.owner_code_first  <= 8'h01;
      cfg_q.owner_code_second <= 8'h02;
      cfg_q.session_flag_mask <= 8'h01;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC:   cfg_q.magic_word        <= cfg_data_i;
        REG_VERSION: cfg_q.supported_version <= cfg_data_i[7:0];
        REG_OWNER_A: cfg_q.owner_code_first  <= cfg_data_i[7:0];
        REG_OWNER_B: cfg_q.owner_code_second <= cfg_data_i[7:0];
        REG_FLAGS:   cfg_q.session_flag_mask <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  shc_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .item_o (item)
  );

  shc_parser #(.HeaderBytes(HeaderBytes)) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .cfg_i  (cfg_q),
    .adv_o  (adv),
    .res_o  (res_o)
  );

`ifndef NO_ASSERTIONS
  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == ST_EMPTY || res_o.status == ST_MAGIC ||
                    res_o.status == ST_CRC)
    |-> (res_o.version == 8'h00 && res_o.owner == 8'h00 && res_o.sequence_res == 32'h0 &&
         res_o.session_tag == 32'h0 && res_o.record_len == 8'h00 && !res_o.session_new))
    else $error("failed header carries nonzero fields");

  a_owner_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.owner != 8'h00 |-> res_o.status == ST_OK)
    else $error("owner given on a header that is not ok");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> res_o.valid && !res_o.ready)
    else $error("input stalled without a waiting result");
`endif

endmodule
